### sv/convex_hull_monotone_chain_top_defines.svh
// assertion macros for the convex hull block
`ifndef CONVEX_HULL_MONOTONE_CHAIN_TOP_DEFINES_SVH
`define CONVEX_HULL_MONOTONE_CHAIN_TOP_DEFINES_SVH
// implication checked on every edge out of reset
`define CHMC_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define CHMC_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");
`endif

### sv/chmc_pkg.sv
// shared types and constants for the convex hull block
`default_nettype none
package chmc_pkg;
  localparam int CoordW = 16;
  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     set_end;
  } in_beat_t;
  typedef struct packed {
    logic signed [CoordW-1:0] hull_x;
    logic signed [CoordW-1:0] hull_y;
    logic                     hull_last;
  } out_beat_t;
  typedef enum logic [3:0] {
    ST_LOAD, ST_SHIFT, ST_RD, ST_RDW, ST_CROSS, ST_MUL, ST_PROD, ST_CMP, ST_PUSH,
    ST_EMIT_RD, ST_EMIT_W, ST_EMIT
  } state_t;
  typedef struct packed {
    logic shift;
    logic load;
    logic rotate;
    logic advance;
  } cell_ctl_t;
endpackage
`default_nettype wire

### sv/chmc_cell.sv
// one cell of the sorted point chain
`default_nettype none
module chmc_cell #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire chmc_pkg::cell_ctl_t     ctl,
  input  wire logic [2*COORD_BITS-1:0] new_pt,
  input  wire logic [2*COORD_BITS-1:0] prev_pt,
  input  wire logic [2*COORD_BITS-1:0] next_pt,
  input  wire logic                    prev_valid,
  input  wire logic                    prev_gt,
  input  wire logic                    fill,
  output logic [2*COORD_BITS-1:0]      pt_r,
  output logic                         valid_r,
  output logic                         gt
);
  logic signed [COORD_BITS-1:0] px, py, nx, ny;
  logic [2*COORD_BITS-1:0] pt_nxt;
  logic valid_nxt;
  assign px = pt_r[2*COORD_BITS-1:COORD_BITS];
  assign py = pt_r[COORD_BITS-1:0];
  assign nx = new_pt[2*COORD_BITS-1:COORD_BITS];
  assign ny = new_pt[COORD_BITS-1:0];
  assign gt = valid_r && (nx < px || (nx == px && ny < py));
  always_comb begin
    pt_nxt = pt_r;
    valid_nxt = valid_r;
    if (ctl.load) begin
      if (gt) begin
        pt_nxt = (prev_gt && prev_valid) ? prev_pt : new_pt;
      end else if (!valid_r && fill) begin
        pt_nxt = prev_gt ? prev_pt : new_pt;
        valid_nxt = 1'b1;
      end
    end else if (ctl.rotate) begin
      pt_nxt = prev_pt;
    end else if (ctl.advance) begin
      pt_nxt = next_pt;
    end
    if (ctl.shift) valid_nxt = 1'b0;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    pt_r <= pt_nxt;
  end
endmodule
`default_nettype wire

### sv/chmc_hull.sv
// hull stack, cross product and emit sequencer
`default_nettype none
module chmc_hull #(
  parameter int MAX_POINTS = 32,
  parameter int COORD_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [$clog2(MAX_POINTS+1)-1:0] n_pts,
  input  wire logic [2*COORD_BITS-1:0] head_pt,
  output logic                         rotate,
  output logic                         advance,
  output logic                         busy,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [2*COORD_BITS-1:0]      out_pt,
  output logic                         out_last
);
  localparam int SD = 2 * MAX_POINTS;
  localparam int SW = $clog2(SD + 1);
  localparam int AW = $clog2(SD);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  chmc_pkg::state_t st_r, st_nxt;
  logic [2*COORD_BITS-1:0] mem [SD];
  logic [SW-1:0] top_r, top_nxt, lim_r, lim_nxt, ek_r, ek_nxt;
  logic [NW-1:0] i_r, i_nxt, n_r;
  logic phase_r, phase_nxt;
  logic [2*COORD_BITS-1:0] a_r, b_r, rd_r, cur_r;
  logic [SW-1:0] ra;
  logic signed [DW-1:0] d1_r, d2_r, d3_r, d4_r;
  logic signed [PW-1:0] p_r, q_r;
  logic signed [COORD_BITS-1:0] ox, oy, ax, ay, bx, by;
  logic we;
  assign ox = a_r[2*COORD_BITS-1:COORD_BITS];
  assign oy = a_r[COORD_BITS-1:0];
  assign ax = b_r[2*COORD_BITS-1:COORD_BITS];
  assign ay = b_r[COORD_BITS-1:0];
  assign bx = cur_r[2*COORD_BITS-1:COORD_BITS];
  assign by = cur_r[COORD_BITS-1:0];
  always_comb begin
    st_nxt = st_r;
    top_nxt = top_r; lim_nxt = lim_r; i_nxt = i_r; phase_nxt = phase_r; ek_nxt = ek_r;
    unique case (st_r)
      chmc_pkg::ST_LOAD: if (start) begin
        st_nxt = chmc_pkg::ST_RD; top_nxt = '0; i_nxt = '0; phase_nxt = 1'b0;
        lim_nxt = SW'(2);
      end
      chmc_pkg::ST_SHIFT: st_nxt = chmc_pkg::ST_RD;
      chmc_pkg::ST_RD: begin
        if (top_r >= lim_r) st_nxt = chmc_pkg::ST_RDW;
        else st_nxt = chmc_pkg::ST_PUSH;
      end
      chmc_pkg::ST_RDW: st_nxt = chmc_pkg::ST_CROSS;
      chmc_pkg::ST_CROSS: st_nxt = chmc_pkg::ST_MUL;
      chmc_pkg::ST_MUL: st_nxt = chmc_pkg::ST_PROD;
      chmc_pkg::ST_PROD: st_nxt = chmc_pkg::ST_CMP;
      chmc_pkg::ST_CMP: begin
        if (p_r <= q_r) begin
          top_nxt = top_r - SW'(1); st_nxt = chmc_pkg::ST_RD;
        end else st_nxt = chmc_pkg::ST_PUSH;
      end
      chmc_pkg::ST_PUSH: begin
        if (top_r < SW'(SD)) top_nxt = top_r + SW'(1);
        st_nxt = chmc_pkg::ST_SHIFT;
        if (!phase_r) begin
          if (i_r + NW'(1) == n_r) begin
            phase_nxt = 1'b1; i_nxt = '0;
            lim_nxt = ((top_r < SW'(SD)) ? top_r + SW'(1) : top_r) + SW'(1);
            if (n_r == NW'(1)) begin
              st_nxt = chmc_pkg::ST_EMIT_RD; ek_nxt = '0;
            end
          end else i_nxt = i_r + NW'(1);
        end else begin
          if (i_r + NW'(2) == n_r) begin
            st_nxt = chmc_pkg::ST_EMIT_RD; ek_nxt = '0;
          end else i_nxt = i_r + NW'(1);
        end
      end
      chmc_pkg::ST_EMIT_RD: st_nxt = chmc_pkg::ST_EMIT_W;
      chmc_pkg::ST_EMIT_W: st_nxt = chmc_pkg::ST_EMIT;
      chmc_pkg::ST_EMIT: if (out_ready) begin
        if (ek_r + SW'(1) == top_r) begin
          st_nxt = chmc_pkg::ST_LOAD; top_nxt = '0;
        end else begin
          ek_nxt = ek_r + SW'(1); st_nxt = chmc_pkg::ST_EMIT_RD;
        end
      end
      default: st_nxt = chmc_pkg::ST_LOAD;
    endcase
  end
  // the chain steps forward through the lower pass and back through the upper one
  always_comb begin
    rotate = 1'b0;
    advance = 1'b0;
    busy = (st_r != chmc_pkg::ST_LOAD);
    out_valid = (st_r == chmc_pkg::ST_EMIT);
    we = (st_r == chmc_pkg::ST_PUSH) && (top_r < SW'(SD));
    ra = ek_r;
    unique case (st_r)
      chmc_pkg::ST_RD: ra = top_r - SW'(2);
      chmc_pkg::ST_RDW: ra = top_r - SW'(1);
      chmc_pkg::ST_PUSH: begin
        if (!phase_r && (i_r + NW'(1) != n_r)) advance = 1'b1;
        else rotate = 1'b1;
      end
      default: ra = ek_r;
    endcase
  end
  assign out_pt = rd_r;
  assign out_last = (ek_r + SW'(1) == top_r);
  always_ff @(posedge clk) begin
    if (we) mem[top_r[AW-1:0]] <= cur_r;
    rd_r <= mem[ra[AW-1:0]];
    if (st_r == chmc_pkg::ST_RDW) a_r <= rd_r;
    if (st_r == chmc_pkg::ST_CROSS) b_r <= rd_r;
    if (st_r == chmc_pkg::ST_RD) cur_r <= head_pt;
    if (st_r == chmc_pkg::ST_LOAD) n_r <= n_pts;
    d1_r <= DW'(ax) - DW'(ox);
    d2_r <= DW'(by) - DW'(oy);
    d3_r <= DW'(ay) - DW'(oy);
    d4_r <= DW'(bx) - DW'(ox);
    p_r <= PW'(d1_r) * PW'(d2_r);
    q_r <= PW'(d3_r) * PW'(d4_r);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= chmc_pkg::ST_LOAD; top_r <= '0; lim_r <= '0; i_r <= '0;
      phase_r <= 1'b0; ek_r <= '0;
    end else begin
      st_r <= st_nxt; top_r <= top_nxt; lim_r <= lim_nxt; i_r <= i_nxt;
      phase_r <= phase_nxt; ek_r <= ek_nxt;
    end
  end
endmodule
`default_nettype wire

### sv/convex_hull_monotone_chain_top.sv
// convex hull top level: sorted cell chain plus hull sequencer
//  channel | dir | beat
//  in_     | in  | point_x, point_y, set_end
//  out_    | out | hull_x, hull_y, hull_last
// a point is sorted into the cell chain on the clock edge that accepts its beat
// after set_end a one-cycle start strobe; each stack test runs RD, RDW, CROSS, MUL, PROD, CMP, each push PUSH, SHIFT
// each emitted vertex steps through EMIT_RD, EMIT_W and EMIT, and EMIT waits out any out_ready stall
// input is held off (in_ready low) from set_end until the last vertex beat
// rst_n is synchronous and clears the chain's valid bits and the sequencer
`default_nettype none
module convex_hull_monotone_chain_top #(
  parameter int MAX_POINTS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire chmc_pkg::in_beat_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output chmc_pkg::out_beat_t     out_data
);
  localparam int COORD_BITS = chmc_pkg::CoordW;
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int PB = 2 * COORD_BITS;
  logic [PB-1:0] pts [MAX_POINTS];
  logic [MAX_POINTS-1:0] vld, gts;
  logic [PB-1:0] new_pt, head_pt, out_pt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic acc, rotate, advance, busy, out_last, start_r;
  chmc_pkg::cell_ctl_t ctl;
  assign in_ready = !busy && !start_r;
  assign acc = in_valid && in_ready;
  assign new_pt = {in_data.point_x[COORD_BITS-1:0], in_data.point_y[COORD_BITS-1:0]};
  assign ctl.load = acc && (cnt_r < NW'(MAX_POINTS));
  assign ctl.rotate = rotate;
  assign ctl.advance = advance;
  assign ctl.shift = out_valid && out_ready && out_last;
  assign head_pt = pts[0];
  genvar g;
  for (g = 0; g < MAX_POINTS; g++) begin : g_cell
    chmc_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .new_pt(new_pt),
      .prev_pt(g == 0 ? pts[MAX_POINTS-1] : pts[g == 0 ? 0 : g-1]),
      .next_pt(g == MAX_POINTS-1 ? pts[0] : pts[g == MAX_POINTS-1 ? 0 : g+1]),
      .prev_valid(g == 0 ? 1'b0 : vld[g == 0 ? 0 : g-1]),
      .prev_gt(g == 0 ? 1'b0 : gts[g == 0 ? 0 : g-1]),
      .fill(cnt_r == NW'(g)),
      .pt_r(pts[g]), .valid_r(vld[g]), .gt(gts[g]));
  end
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.load) cnt_nxt = cnt_r + NW'(1);
    if (ctl.shift) cnt_nxt = '0;
  end
  chmc_hull #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_hull (
    .clk(clk), .rst_n(rst_n), .start(start_r), .n_pts(cnt_r), .head_pt(head_pt),
    .rotate(rotate), .advance(advance), .busy(busy), .out_valid(out_valid),
    .out_ready(out_ready), .out_pt(out_pt), .out_last(out_last));
  assign out_data.hull_x = out_pt[PB-1:COORD_BITS];
  assign out_data.hull_y = out_pt[COORD_BITS-1:0];
  assign out_data.hull_last = out_last;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; start_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      start_r <= acc && in_data.set_end;
    end
  end
endmodule
`default_nettype wire

### sv/chmc_checker.sv
// port-level assertions for the convex hull block
`include "convex_hull_monotone_chain_top_defines.svh"
`default_nettype none
module chmc_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire chmc_pkg::in_beat_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire chmc_pkg::out_beat_t out_data
);
  `CHMC_ASSERT_IMP(a_excl, clk, rst_n, out_valid, !in_ready)
  `CHMC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `CHMC_ASSERT_NEXT(a_end, clk, rst_n, in_valid && in_ready && in_data.set_end, !in_ready)
endmodule
bind convex_hull_monotone_chain_top chmc_checker u_chk (.*);
`default_nettype wire
